// File: src/bkd_pkg.sv
// Shared types, constants and pointer helpers for the bounded keyed deque.
package bkd_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_BITS  = 32;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(DEPTH + 1);
	localparam int KEY_W     = 32;
	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 5;
	localparam int CFG_W     = 5;
	localparam int MAX_RESET = 16;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_REMOVE     = 3'd4,
		OP_SEARCH     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// logical position to physical slot of the ring
	function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
		input logic [AW-1:0] lpos);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, lpos};
		if (sum >= (AW+1)'(DEPTH))
			sum = sum - (AW+1)'(DEPTH);
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

endpackage

// File: src/bounded_keyed_deque_unit.sv
// Bounded keyed deque: ring buffer in a two-port memory under a small sequencer.
// Requests are taken one at a time; ready is high only while the sequencer is idle.
// Entries live in a ring of DEPTH slots read through one registered read port, so
// every entry examined passes through an issue and a compare state. Search and
// remove examine one entry at a time (remove checks head, tail, then the middle
// from the front); removing a middle entry moves each later entry down with a
// read and a write state. The result sits in an output register; the next
// request is taken as soon as it has been loaded there.
// Pushes beyond min(max_entries, DEPTH) are refused with a full status.
module bounded_keyed_deque_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bkd_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  op,
	input  logic [bkd_pkg::KEY_W-1:0]   key,
	input  logic [bkd_pkg::DATA_W-1:0]  payload,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [bkd_pkg::KEY_W-1:0]   out_key,
	output logic [bkd_pkg::DATA_W-1:0]  out_payload,
	output logic [bkd_pkg::COUNT_W-1:0] count
);
	import bkd_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_POP   = 7'b0000010,
		S_ISSUE = 7'b0000100,
		S_CMP   = 7'b0001000,
		S_SHRD  = 7'b0010000,
		S_SHWR  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [CFG_W-1:0]    max_q;
	logic [AW-1:0]       scan_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       shift_q;
	logic                out_valid_q;

	logic [2:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	status_t             res_status_q;
	logic [KEY_BITS-1:0] res_key_q;
	logic [DATA_W-1:0]   res_pl_q;
	status_t             out_status_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [DATA_W-1:0]   out_pl_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic [KEY_BITS-1:0] mem_key [DEPTH];
	logic [DATA_W-1:0]   mem_pl  [DEPTH];
	logic [KEY_BITS-1:0] rd_key_q;
	logic [DATA_W-1:0]   rd_pl_q;

	logic                mem_we;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	logic [KEY_BITS-1:0] wkey;
	logic [DATA_W-1:0]   wpl;

	logic                accept;
	logic                full;
	logic                empty;
	logic                out_free;
	logic                hit;
	logic [KEY_BITS-1:0] key_in;
	logic [AW-1:0]       scan_pos;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign key_in   = KEY_BITS'(key);
	assign empty    = (count_q == '0);
	assign full     = (32'(count_q) >= 32'(max_q)) || (32'(count_q) >= 32'(DEPTH));
	assign out_free = !out_valid_q || out_ready;
	assign hit      = (rd_key_q == key_q);

	// remove walks head, tail, then middle; search walks front to rear
	always_comb begin
		if (op_q == OP_SEARCH)
			scan_pos = scan_q;
		else if (scan_q == '0)
			scan_pos = '0;
		else if (scan_q == AW'(1))
			scan_pos = AW'(count_q - 1'b1);
		else
			scan_pos = scan_q - 1'b1;
	end

	always_comb begin
		mem_we = 1'b0;
		waddr  = '0;
		raddr  = '0;
		wkey   = key_in;
		wpl    = payload;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_PUSH_FRONT: begin
							mem_we = !full;
							waddr  = ptr_dec(head_q);
						end
						OP_PUSH_REAR: begin
							mem_we = !full;
							waddr  = phys_addr(head_q, AW'(count_q));
						end
						OP_POP_FRONT: raddr = head_q;
						OP_POP_REAR:  raddr = phys_addr(head_q, AW'(count_q - 1'b1));
						default: ;
					endcase
				end
			end
			S_ISSUE: raddr = phys_addr(head_q, scan_pos);
			S_SHRD:  raddr = phys_addr(head_q, shift_q + 1'b1);
			S_SHWR: begin
				mem_we = 1'b1;
				waddr  = phys_addr(head_q, shift_q);
				wkey   = rd_key_q;
				wpl    = rd_pl_q;
			end
			S_POP, S_CMP, S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_key[waddr] <= wkey;
			mem_pl[waddr]  <= wpl;
		end
		rd_key_q <= mem_key[raddr];
		rd_pl_q  <= mem_pl[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			max_q       <= CFG_W'(MAX_RESET);
			scan_q      <= '0;
			pos_q       <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				max_q <= cfg_wdata;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						scan_q  <= '0;
						case (op)
							OP_PUSH_FRONT, OP_PUSH_REAR: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
									if (op == OP_PUSH_FRONT)
										head_q <= ptr_dec(head_q);
								end
							end
							OP_POP_FRONT, OP_POP_REAR: begin
								if (!empty)
									state_q <= S_POP;
							end
							OP_REMOVE: begin
								if (!empty)
									state_q <= S_ISSUE;
							end
							OP_SEARCH: begin
								if (!empty && key_in != '0)
									state_q <= S_ISSUE;
							end
							default: ;
						endcase
					end
				end
				S_POP: begin
					if (op_q == OP_POP_FRONT)
						head_q <= ptr_inc(head_q);
					count_q <= count_q - 1'b1;
					state_q <= S_DONE;
				end
				S_ISSUE: begin
					pos_q   <= scan_pos;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_DONE;
						if (op_q == OP_REMOVE) begin
							if (pos_q == '0) begin
								head_q  <= ptr_inc(head_q);
								count_q <= count_q - 1'b1;
							end else if (32'(pos_q) + 32'd1 == 32'(count_q)) begin
								count_q <= count_q - 1'b1;
							end else begin
								shift_q <= pos_q;
								state_q <= S_SHRD;
							end
						end
					end else if (32'(scan_q) + 32'd1 < 32'(count_q)) begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_ISSUE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (32'(shift_q) + 32'd2 < 32'(count_q)) begin
						shift_q <= shift_q + 1'b1;
						state_q <= S_SHRD;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= op;
			key_q        <= key_in;
			res_status_q <= ST_OK;
			res_key_q    <= '0;
			res_pl_q     <= '0;
			case (op)
				OP_PUSH_FRONT, OP_PUSH_REAR: begin
					res_key_q    <= key_in;
					res_pl_q     <= payload;
					res_status_q <= full ? ST_FULL : ST_OK;
				end
				OP_POP_FRONT, OP_POP_REAR, OP_REMOVE: begin
					if (empty)
						res_status_q <= ST_EMPTY;
				end
				OP_SEARCH: begin
					if (empty || key_in == '0)
						res_status_q <= ST_NOTFOUND;
				end
				default: ;
			endcase
		end
		if (state_q == S_POP || (state_q == S_CMP && hit)) begin
			res_key_q <= rd_key_q;
			res_pl_q  <= rd_pl_q;
		end
		if (state_q == S_CMP && !hit && !(32'(scan_q) + 32'd1 < 32'(count_q)))
			res_status_q <= ST_NOTFOUND;
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_key_q    <= KEY_W'(res_key_q);
			out_pl_q     <= res_pl_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign out_key     = out_key_q;
	assign out_payload = out_pl_q;
	assign count       = out_count_q;

endmodule

// File: src/bkd_checker.sv
// Port-level assertions for the bounded keyed deque, bound to the top level.
module bkd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  status,
	input logic [bkd_pkg::KEY_W-1:0]   out_key,
	input logic [bkd_pkg::DATA_W-1:0]  out_payload,
	input logic [bkd_pkg::COUNT_W-1:0] count
);
	import bkd_pkg::*;

	// a taken request leaves the sequencer busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a request was taken");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> count == '0)
		else $error("empty status with entries held");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY || status == ST_NOTFOUND)
		|-> out_key == '0 && out_payload == '0)
		else $error("entry fields not zero on empty or not-found result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(count) <= 32'(DEPTH))
		else $error("count beyond depth");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_key)
		&& $stable(out_payload) && $stable(count))
		else $error("stalled result changed");

endmodule

bind bounded_keyed_deque_unit bkd_checker u_bkd_checker (.*);
